// ===== sv/wsfp_pkg.sv =====
// wsfp_pkg: shared types for the websocket frame parser
// no dependencies; used by wsfp_core, wsfp_skid and websocket_frame_parser
`default_nettype none

package wsfp_pkg;

  localparam int unsigned LenW  = 64;
  localparam int unsigned ByteW = 8;

  // one parse result, produced for every accepted stream byte
  typedef struct packed {
    logic             fin;
    logic [2:0]       rsv_bits;
    logic [3:0]       opcode;
    logic             masked;
    logic [LenW-1:0]  payload_length;
    logic             header_ready;
    logic             payload_valid;
    logic [ByteW-1:0] payload_byte;
    logic [LenW-1:0]  payload_offset;
    logic             frame_done;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/wsfp_core.sv =====
// wsfp_core: header parse state and per-byte result logic
// depends on wsfp_pkg
`default_nettype none

module wsfp_core
  import wsfp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             fire_i,
  input  wire logic [ByteW-1:0] data_byte_i,
  output result_t               res_o
);

  typedef enum logic [2:0] {
    PH_HDR1,
    PH_HDR2,
    PH_LEN2,
    PH_LEN8,
    PH_KEY,
    PH_PAYLOAD
  } phase_e;

  localparam logic [6:0] Len7Max = 7'd125;
  localparam logic [6:0] Len7Ext16 = 7'd126;
  localparam logic [3:0] Len2Bytes = 4'd2;
  localparam logic [3:0] Len8Bytes = 4'd8;
  localparam logic [3:0] KeyBytes = 4'd4;

  phase_e          phase_q, phase_d, phase_nx;
  logic            fin_q, fin_d;
  logic [2:0]      rsv_q, rsv_d;
  logic [3:0]      opc_q, opc_d;
  logic            mask_q, mask_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] rcv_q, rcv_d, rcv_nx;
  logic [31:0]     key_q, key_d;
  logic [3:0]      cnt_q, cnt_d;
  logic [3:0]      cnt_inc;
  logic [6:0]      len7;
  logic [ByteW-1:0] key_byte;
  logic            ready, pvalid, done;

  assign cnt_inc = cnt_q + 4'd1;
  assign len7    = data_byte_i[6:0];
  assign rcv_nx  = rcv_q + LenW'(1);

  always_comb begin
    case (rcv_q[1:0])
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_nx = phase_q;
    fin_d    = fin_q;
    rsv_d    = rsv_q;
    opc_d    = opc_q;
    mask_d   = mask_q;
    len_d    = len_q;
    rcv_d    = rcv_q;
    key_d    = key_q;
    cnt_d    = cnt_q;
    ready    = 1'b0;
    pvalid   = 1'b0;
    done     = 1'b0;
    res_o    = '0;

    case (phase_q)
      PH_HDR1: begin
        fin_d    = data_byte_i[7];
        rsv_d    = data_byte_i[6:4];
        opc_d    = data_byte_i[3:0];
        phase_nx = PH_HDR2;
      end
      PH_HDR2: begin
        mask_d = data_byte_i[7];
        rcv_d  = '0;
        cnt_d  = '0;
        if (len7 <= Len7Max) begin
          len_d = LenW'(len7);
          if (data_byte_i[7]) begin
            phase_nx = PH_KEY;
          end else begin
            ready    = 1'b1;
            phase_nx = PH_PAYLOAD;
            done     = (len7 == 7'd0);
          end
        end else begin
          len_d    = '0;
          phase_nx = (len7 == Len7Ext16) ? PH_LEN2 : PH_LEN8;
        end
      end
      PH_LEN2, PH_LEN8: begin
        len_d = {len_q[LenW-ByteW-1:0], data_byte_i};
        cnt_d = cnt_inc;
        if (cnt_inc == ((phase_q == PH_LEN2) ? Len2Bytes : Len8Bytes)) begin
          cnt_d = '0;
          if (mask_q) begin
            phase_nx = PH_KEY;
          end else begin
            ready    = 1'b1;
            phase_nx = PH_PAYLOAD;
            done     = (len_d == '0);
          end
        end
      end
      PH_KEY: begin
        key_d = {key_q[23:0], data_byte_i};
        cnt_d = cnt_inc;
        if (cnt_inc >= KeyBytes) begin
          cnt_d    = '0;
          ready    = 1'b1;
          phase_nx = PH_PAYLOAD;
          done     = (len_q == '0);
        end
      end
      PH_PAYLOAD: begin
        pvalid             = 1'b1;
        res_o.payload_offset = rcv_q;
        res_o.payload_byte = mask_q ? (data_byte_i ^ key_byte) : data_byte_i;
        rcv_d              = rcv_nx;
        done               = (rcv_nx >= len_q);
      end
      default: begin
        phase_nx = PH_HDR1;
      end
    endcase

    res_o.fin            = fin_d;
    res_o.rsv_bits       = rsv_d;
    res_o.opcode         = opc_d;
    res_o.masked         = mask_d;
    res_o.payload_length = len_d;
    res_o.header_ready   = ready;
    res_o.payload_valid  = pvalid;
    res_o.frame_done     = done;

    // frame end returns every field to its idle value
    phase_d = phase_nx;
    if (done) begin
      phase_d = PH_HDR1;
      fin_d   = 1'b0;
      rsv_d   = '0;
      opc_d   = '0;
      mask_d  = 1'b0;
      len_d   = '0;
      rcv_d   = '0;
      key_d   = '0;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR1;
      fin_q   <= 1'b0;
      rsv_q   <= '0;
      opc_q   <= '0;
      mask_q  <= 1'b0;
      len_q   <= '0;
      rcv_q   <= '0;
      key_q   <= '0;
      cnt_q   <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      fin_q   <= fin_d;
      rsv_q   <= rsv_d;
      opc_q   <= opc_d;
      mask_q  <= mask_d;
      len_q   <= len_d;
      rcv_q   <= rcv_d;
      key_q   <= key_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/wsfp_skid.sv =====
// wsfp_skid: output register with one skid entry for parse results
// depends on wsfp_pkg
`default_nettype none

module wsfp_skid
  import wsfp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    valid_i,
  output logic         stall_o,
  input  wire result_t data_i,
  output logic         valid_o,
  input  wire logic    stall_i,
  output result_t      data_o
);

  logic    out_vld_q, skid_vld_q;
  result_t out_q, skid_q;
  logic    accept, out_free;

  assign stall_o  = skid_vld_q;
  assign accept   = valid_i && !skid_vld_q;
  assign out_free = !out_vld_q || !stall_i;
  assign valid_o  = out_vld_q;
  assign data_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_free) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= accept;
      end
    end else if (accept) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= data_i;
      end
    end else if (accept) begin
      skid_q <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/websocket_frame_parser.sv =====
// websocket_frame_parser: top level of the websocket receive-side frame parser
// depends on wsfp_pkg, wsfp_core and wsfp_skid
`default_nettype none

// Takes one stream byte per request and returns exactly one result request
// per byte. Header bytes (first byte, length byte, 2 or 8 big-endian length
// bytes, 4 key bytes when masked) update fin/rsv_bits/opcode/masked/
// payload_length; header_ready pulses on the byte that completes the header.
// Payload bytes come out unmasked with their offset; frame_done marks the
// last byte of a frame (or the header-completing byte of an empty frame).
// Headers are not checked. Rate: one byte per clock while in_stall_o is
// low; each result is registered in the output register, or in the skid
// entry while the output side stalls. The parse state is updated when a byte
// is taken; a one-entry skid takes one more byte when the output side stalls.
module websocket_frame_parser
  import wsfp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [ByteW-1:0]  data_byte_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   fin_o,
  output logic [2:0]             rsv_bits_o,
  output logic [3:0]             opcode_o,
  output logic                   masked_o,
  output logic [LenW-1:0]        payload_length_o,
  output logic                   header_ready_o,
  output logic                   payload_valid_o,
  output logic [ByteW-1:0]       payload_byte_o,
  output logic [LenW-1:0]        payload_offset_o,
  output logic                   frame_done_o
);

  logic    in_fire;
  result_t res_now, res_out;

  // a byte is taken whenever it is offered and the skid entry is free
  assign in_fire = in_valid_i && !in_stall_o;

  wsfp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (in_fire),
    .data_byte_i (data_byte_i),
    .res_o       (res_now)
  );

  wsfp_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .data_i  (res_now),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (res_out)
  );

  // unpack the result register onto the ports
  assign fin_o            = res_out.fin;
  assign rsv_bits_o       = res_out.rsv_bits;
  assign opcode_o         = res_out.opcode;
  assign masked_o         = res_out.masked;
  assign payload_length_o = res_out.payload_length;
  assign header_ready_o   = res_out.header_ready;
  assign payload_valid_o  = res_out.payload_valid;
  assign payload_byte_o   = res_out.payload_byte;
  assign payload_offset_o = res_out.payload_offset;
  assign frame_done_o     = res_out.frame_done;

  // skid entry only fills behind a held output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("skid entry full while output register empty");

  // a payload byte never completes a header
  a_payload_not_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && payload_valid_o) |-> !header_ready_o)
    else $error("payload byte flagged as header end");

  // the last payload byte sits at offset length-1
  a_last_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && payload_valid_o && frame_done_o)
      |-> (LenW'(payload_offset_o + LenW'(1)) == payload_length_o))
    else $error("frame ended at wrong payload offset");

  // a held result stays valid and keeps its payload offset
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(payload_offset_o)))
    else $error("stalled result changed");

endmodule

`default_nettype wire
